// ----- rtl/core/ctb_pkg.sv -----
// ctb_pkg: command and status codes and fixed field widths of the cursor text buffer
// no dependencies; used by the channel interfaces and all rtl/core modules
`default_nettype none

package ctb_pkg;

   localparam int unsigned KIND_W  = 3;
   localparam int unsigned CH_W    = 8;
   localparam int unsigned INDEX_W = 10;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned LEN_W   = 11;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT    = 3'd0,
      KIND_LEFT      = 3'd1,
      KIND_RIGHT     = 3'd2,
      KIND_BACKSPACE = 3'd3,
      KIND_READ      = 3'd4
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE     = 2'd0,
      ST_NOEFFECT = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/ctb_if.sv -----
// ctb_req_if / ctb_rsp_if: valid/ready channels for editor requests and responses
// depends on ctb_pkg
`default_nettype none

interface ctb_req_if;
   logic                       valid;
   logic                       ready;
   ctb_pkg::kind_type          kind;
   logic [ctb_pkg::CH_W-1:0]    ch;
   logic [ctb_pkg::INDEX_W-1:0] read_index;

   modport source (output valid, output kind, output ch, output read_index, input ready);
   modport sink   (input valid, input kind, input ch, input read_index, output ready);
endinterface

interface ctb_rsp_if;
   logic                     valid;
   logic                     ready;
   ctb_pkg::status_type      status;
   logic [ctb_pkg::CH_W-1:0]  read_byte;
   logic [ctb_pkg::LEN_W-1:0] text_length;
   logic [ctb_pkg::LEN_W-1:0] cursor_position;

   modport source (output valid, output status, output read_byte, output text_length,
                   output cursor_position, input ready);
   modport sink   (input valid, input status, input read_byte, input text_length,
                   input cursor_position, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ctb_ram.sv -----
// ctb_ram: simple dual-port text store, one write and one registered read per cycle
// depends on ctb_pkg for the byte width
`default_nettype none

module ctb_ram #(
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [ctb_pkg::CH_W-1:0]   wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [ctb_pkg::CH_W-1:0]   rd_data
);

   logic [ctb_pkg::CH_W-1:0] mem [DEPTH];
   logic [ctb_pkg::CH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/cursor_text_buffer.sv -----
// cursor_text_buffer: gap-buffer line editor with a cursor
// depends on ctb_pkg, ctb_req_if, ctb_rsp_if and ctb_ram
//
// usage: each request on req_if carries one command (insert, cursor left,
// cursor right, backspace, read byte) and produces exactly one response on
// rsp_if with a status, the byte read, the text length and the cursor place.
// the text lives in one ram of CAPACITY bytes: bytes left of the cursor at the
// bottom, bytes right of the cursor at the top, the gap between them.
// each request is accepted in the idle state, and its ram read is issued in the accept
// cycle; the write-back of a cursor move and the loading of the response register
// follow in the access state, so no request is taken until the last one leaves it.
// a new request is taken while the previous response still waits; if the
// receiver stalls, the next request is held in the access state until the
// response register frees, and req ready stays low meanwhile.
// reset (synchronous): text empties and the cursor goes to position 0; ram
// contents are not cleared, since no command can read an unwritten byte.
`default_nettype none

module cursor_text_buffer #(
   parameter int unsigned CAPACITY = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ctb_req_if.sink    req_if,
   ctb_rsp_if.source  rsp_if
);

   localparam int unsigned ADDR_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
   localparam int unsigned WIDE_W = CNT_W + ctb_pkg::INDEX_W + ctb_pkg::LEN_W;

   typedef enum logic {
      S_IDLE,
      S_ACCESS
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]            left_ff, left_in;
   logic [CNT_W-1:0]            right_ff, right_in;
   ctb_pkg::status_type         stat_ff, stat_in;
   logic                       rd_ok_ff, rd_ok_in;
   logic                       mv_wr_ff, mv_wr_in;
   logic [ADDR_W-1:0]           mv_addr_ff, mv_addr_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   ctb_pkg::status_type         rsp_stat_ff, rsp_stat_in;
   logic [ctb_pkg::CH_W-1:0]    rsp_byte_ff, rsp_byte_in;
   logic [ctb_pkg::LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [ctb_pkg::LEN_W-1:0]   rsp_cur_ff, rsp_cur_in;

   logic                       wr_en, rd_en;
   logic [ADDR_W-1:0]           wr_addr, rd_addr;
   logic [ctb_pkg::CH_W-1:0]    wr_data, rd_data;

   logic [CNT_W-1:0]            len;
   logic [CNT_W-1:0]            top_base;
   logic [WIDE_W-1:0]           idx_wide, len_wide, left_wide;
   logic [CNT_W-1:0]            idx_cnt;
   logic [CNT_W-1:0]            phys;

   ctb_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // position arithmetic on the current counts
   always_comb begin
      len       = left_ff + right_ff;
      top_base  = CNT_W'(CAPACITY) - right_ff;
      idx_wide  = {{(WIDE_W - ctb_pkg::INDEX_W){1'b0}}, req_if.read_index};
      len_wide  = {{(WIDE_W - CNT_W){1'b0}}, len};
      left_wide = {{(WIDE_W - CNT_W){1'b0}}, left_ff};
      idx_cnt   = idx_wide[CNT_W-1:0];
      if (idx_wide < left_wide) begin
         phys = idx_cnt;
      end else begin
         phys = top_base + idx_cnt - left_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      stat_in      = stat_ff;
      rd_ok_in     = rd_ok_ff;
      mv_wr_in     = mv_wr_ff;
      mv_addr_in   = mv_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_cur_in   = rsp_cur_ff;
      wr_en        = 1'b0;
      wr_addr      = left_ff[ADDR_W-1:0];
      wr_data      = req_if.ch;
      rd_en        = 1'b0;
      rd_addr      = phys[ADDR_W-1:0];
      req_if.ready = (state_ff == S_IDLE);

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               state_in = S_ACCESS;
               stat_in  = ctb_pkg::ST_DONE;
               rd_ok_in = 1'b0;
               mv_wr_in = 1'b0;
               case (req_if.kind)
                  ctb_pkg::KIND_INSERT: begin
                     if (len == CNT_W'(CAPACITY)) begin
                        stat_in = ctb_pkg::ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        left_in = left_ff + 1'b1;
                     end
                  end
                  ctb_pkg::KIND_LEFT: begin
                     if (left_ff == '0) begin
                        stat_in = ctb_pkg::ST_NOEFFECT;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(left_ff - 1'b1);
                        mv_wr_in   = 1'b1;
                        mv_addr_in = ADDR_W'(top_base - 1'b1);
                        left_in    = left_ff - 1'b1;
                        right_in   = right_ff + 1'b1;
                     end
                  end
                  ctb_pkg::KIND_RIGHT: begin
                     if (right_ff == '0) begin
                        stat_in = ctb_pkg::ST_NOEFFECT;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = top_base[ADDR_W-1:0];
                        mv_wr_in   = 1'b1;
                        mv_addr_in = left_ff[ADDR_W-1:0];
                        left_in    = left_ff + 1'b1;
                        right_in   = right_ff - 1'b1;
                     end
                  end
                  ctb_pkg::KIND_BACKSPACE: begin
                     if (left_ff == '0) begin
                        stat_in = ctb_pkg::ST_NOEFFECT;
                     end else begin
                        left_in = left_ff - 1'b1;
                     end
                  end
                  ctb_pkg::KIND_READ: begin
                     if (idx_wide >= len_wide) begin
                        stat_in = ctb_pkg::ST_NOEFFECT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_ok_in = 1'b1;
                     end
                  end
                  default: begin
                     stat_in = ctb_pkg::ST_NOEFFECT;
                  end
               endcase
            end
         end
         S_ACCESS: begin
            // finish once the response register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               wr_en        = mv_wr_ff;
               wr_addr      = mv_addr_ff;
               wr_data      = rd_data;
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_byte_in  = rd_ok_ff ? rd_data : '0;
               rsp_len_in   = ctb_pkg::LEN_W'({{ctb_pkg::LEN_W{1'b0}}, len});
               rsp_cur_in   = ctb_pkg::LEN_W'({{ctb_pkg::LEN_W{1'b0}}, left_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         left_ff      <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         mv_wr_ff     <= 1'b0;
         rd_ok_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
         mv_wr_ff     <= mv_wr_in;
         rd_ok_ff     <= rd_ok_in;
      end
      stat_ff     <= stat_in;
      mv_addr_ff  <= mv_addr_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_cur_ff  <= rsp_cur_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_stat_ff;
   assign rsp_if.read_byte       = rsp_byte_ff;
   assign rsp_if.text_length     = rsp_len_ff;
   assign rsp_if.cursor_position = rsp_cur_ff;

endmodule

`default_nettype wire

// ----- tb/cursor_text_buffer_tb.sv -----
`timescale 1ns / 1ps
// cursor_text_buffer_tb: drives editor requests and checks every response against a gap-buffer
// tracker kept in a small scoreboard class; depends on ctb_pkg, ctb_req_if, ctb_rsp_if and
// cursor_text_buffer, built here at its full capacity

module cursor_text_buffer_tb;

   localparam int unsigned CAP         = 1024;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned PHASES      = 4;
   localparam int unsigned PHASE_ITEMS = 100;

   localparam int unsigned KIND_W  = ctb_pkg::KIND_W;
   localparam int unsigned CH_W    = ctb_pkg::CH_W;
   localparam int unsigned INDEX_W = ctb_pkg::INDEX_W;
   localparam int unsigned LEN_W   = ctb_pkg::LEN_W;

   localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

   typedef enum int unsigned {MIX_GROW, MIX_SHRINK, MIX_WANDER} mix_type;

   typedef struct {
      ctb_pkg::status_type status;
      logic [CH_W-1:0]     read_byte;
      logic [LEN_W-1:0]    text_length;
      logic [LEN_W-1:0]    cursor_position;
   } edit_result_type;

   class text_tracker;
      logic [CH_W-1:0] text_mem [CAP];
      int unsigned     left_n;
      int unsigned     right_n;
      edit_result_type pending[$];
      int unsigned     mismatches;

      function new();
         left_n     = 0;
         right_n    = 0;
         mismatches = 0;
         foreach (text_mem[i]) text_mem[i] = '0;
      endfunction

      function int unsigned text_len();
         return left_n + right_n;
      endfunction

      function void apply_request(logic [KIND_W-1:0] k, logic [CH_W-1:0] c,
                                  logic [INDEX_W-1:0] idx);
         edit_result_type r;
         int unsigned     len;
         len         = left_n + right_n;
         r.status    = ctb_pkg::ST_DONE;
         r.read_byte = '0;
         case (k)
            ctb_pkg::KIND_INSERT: begin
               if (len >= CAP) begin
                  r.status = ctb_pkg::ST_FULL;
               end else begin
                  text_mem[left_n] = c;
                  left_n++;
               end
            end
            ctb_pkg::KIND_LEFT: begin
               if (left_n == 0) begin
                  r.status = ctb_pkg::ST_NOEFFECT;
               end else begin
                  left_n--;
                  right_n++;
                  text_mem[CAP - right_n] = text_mem[left_n];
               end
            end
            ctb_pkg::KIND_RIGHT: begin
               if (right_n == 0) begin
                  r.status = ctb_pkg::ST_NOEFFECT;
               end else begin
                  text_mem[left_n] = text_mem[CAP - right_n];
                  left_n++;
                  right_n--;
               end
            end
            ctb_pkg::KIND_BACKSPACE: begin
               if (left_n == 0) begin
                  r.status = ctb_pkg::ST_NOEFFECT;
               end else begin
                  left_n--;
               end
            end
            ctb_pkg::KIND_READ: begin
               if (idx >= len) begin
                  r.status = ctb_pkg::ST_NOEFFECT;
               end else if (idx < left_n) begin
                  r.read_byte = text_mem[idx];
               end else begin
                  r.read_byte = text_mem[CAP - right_n + (idx - left_n)];
               end
            end
            default: begin
               r.status = ctb_pkg::ST_NOEFFECT;
            end
         endcase
         r.text_length     = LEN_W'(left_n + right_n);
         r.cursor_position = LEN_W'(left_n);
         pending.push_back(r);
      endfunction

      function void check_response(ctb_pkg::status_type s, logic [CH_W-1:0] b,
                                   logic [LEN_W-1:0] l, logic [LEN_W-1:0] c);
         edit_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: response with no request pending:", $realtime);
               $display("%0t:   status %0d byte %02h len %0d cursor %0d",
                        $realtime, s, b, l, c);
            end
            return;
         end
         e = pending.pop_front();
         if (s !== e.status || b !== e.read_byte || l !== e.text_length ||
             c !== e.cursor_position) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: mismatch: expected status %0d byte %02h len %0d cursor %0d",
                        $realtime, e.status, e.read_byte, e.text_length, e.cursor_position);
               $display("%0t:           got      status %0d byte %02h len %0d cursor %0d",
                        $realtime, s, b, l, c);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ctb_req_if req_if();
   ctb_rsp_if rsp_if();

   cursor_text_buffer #(.CAPACITY(CAP)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   text_tracker edits = new();

   int unsigned send_idle_pct;
   int unsigned stall_pct;
   logic        hold_req;
   logic        hold_off;

   int unsigned kind_mix [3][5] = '{'{55, 65, 75, 80, 98},
                                   '{10, 25, 35, 75, 98},
                                   '{25, 45, 65, 77, 98}};
   int unsigned phase_idle [PHASES] = '{0, 83, 0, 20};
   int unsigned phase_stall [PHASES] = '{0, 0, 83, 20};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // long receiver hold-off so the block fills up and stalls its request side
   initial begin
      hold_off = 1'b0;
      wait (hold_req === 1'b1);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(negedge clock) begin
      rsp_if.ready = !hold_off && ($urandom_range(99, 0) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         edits.check_response(rsp_if.status, rsp_if.read_byte, rsp_if.text_length,
                              rsp_if.cursor_position);
      end
   end

   task automatic send(logic [KIND_W-1:0] k, logic [CH_W-1:0] c, logic [INDEX_W-1:0] idx);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid      = 1'b1;
      req_if.kind       = ctb_pkg::kind_type'(k);
      req_if.ch         = c;
      req_if.read_index = idx;
      do @(posedge clock); while (!req_if.ready);
      edits.apply_request(k, c, idx);
   endtask

   task automatic random_edits(int unsigned count);
      mix_type            mix;
      int unsigned        r;
      int unsigned        len;
      logic [KIND_W-1:0]  k;
      logic [INDEX_W-1:0] idx;
      mix = MIX_WANDER;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            mix = mix_type'($urandom_range(2, 0));
         end
         r = $urandom_range(99, 0);
         if (r < kind_mix[mix][0]) begin
            k = ctb_pkg::KIND_INSERT;
         end else if (r < kind_mix[mix][1]) begin
            k = ctb_pkg::KIND_LEFT;
         end else if (r < kind_mix[mix][2]) begin
            k = ctb_pkg::KIND_RIGHT;
         end else if (r < kind_mix[mix][3]) begin
            k = ctb_pkg::KIND_BACKSPACE;
         end else if (r < kind_mix[mix][4]) begin
            k = ctb_pkg::KIND_READ;
         end else begin
            k = KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
         end
         len = edits.text_len();
         if (k == ctb_pkg::KIND_READ && len > 0 && $urandom_range(99, 0) < 70) begin
            idx = INDEX_W'($urandom_range(len - 1, 0));
         end else if (k == ctb_pkg::KIND_READ && $urandom_range(1, 0) == 1) begin
            idx = INDEX_W'(len);
         end else begin
            idx = INDEX_W'($urandom_range(1023, 0));
         end
         send(k, CH_W'($urandom_range(255, 0)), idx);
      end
   endtask

   initial begin
      req_if.valid      = 1'b0;
      req_if.kind       = ctb_pkg::KIND_INSERT;
      req_if.ch         = '0;
      req_if.read_index = '0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      hold_req          = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // empty text: every command but insert has no effect; then inserts, moves, reads
      send(ctb_pkg::KIND_READ, 8'h00, 10'd0);
      send(ctb_pkg::KIND_LEFT, 8'h00, 10'd0);
      send(ctb_pkg::KIND_RIGHT, 8'h00, 10'd0);
      send(ctb_pkg::KIND_BACKSPACE, 8'h00, 10'd0);
      send(KIND_UNUSED_FIRST, 8'hff, '1);
      send(KIND_UNUSED_LAST, 8'h00, 10'd0);
      send(ctb_pkg::KIND_INSERT, 8'h00, 10'd0);
      send(ctb_pkg::KIND_INSERT, 8'hff, '1);
      send(ctb_pkg::KIND_LEFT, 8'h00, 10'd0);
      send(ctb_pkg::KIND_LEFT, 8'h00, 10'd0);
      send(ctb_pkg::KIND_LEFT, 8'h00, 10'd0);
      send(ctb_pkg::KIND_READ, 8'h00, 10'd1);
      send(ctb_pkg::KIND_READ, 8'h00, 10'd2);
      send(ctb_pkg::KIND_READ, 8'h00, '1);
      send(ctb_pkg::KIND_RIGHT, 8'h00, 10'd0);
      send(ctb_pkg::KIND_BACKSPACE, 8'h00, 10'd0);
      send(ctb_pkg::KIND_RIGHT, 8'h00, 10'd0);
      send(ctb_pkg::KIND_RIGHT, 8'h00, 10'd0);

      // inserts around a cursor move, then a read past the end and a backspace
      send(ctb_pkg::KIND_INSERT, 8'ha5, 10'd0);
      send(ctb_pkg::KIND_LEFT, 8'h00, 10'd0);
      send(ctb_pkg::KIND_INSERT, 8'h5a, 10'd0);
      send(ctb_pkg::KIND_READ, 8'h00, INDEX_W'(CAP - 1));
      send(ctb_pkg::KIND_BACKSPACE, 8'h00, 10'd0);

      for (int unsigned p = 0; p < PHASES; p++) begin
         send_idle_pct = phase_idle[p];
         stall_pct     = phase_stall[p];
         if (p == 0) begin
            hold_req = 1'b1;
         end
         random_edits(PHASE_ITEMS);
      end

      @(negedge clock);
      req_if.valid = 1'b0;
      while (edits.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (edits.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- cursor_text_buffer.f -----
rtl/core/ctb_pkg.sv
rtl/core/ctb_if.sv
rtl/core/ctb_ram.sv
rtl/core/cursor_text_buffer.sv
tb/cursor_text_buffer_tb.sv
